>>> rtl/set_assoc_cache_lru_lfu_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the set-associative cache tag block
// Short forms for the clocked properties used by the RTL, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_CACHE_LRU_LFU_TOP_ASSERT_SVH
`define SET_ASSOC_CACHE_LRU_LFU_TOP_ASSERT_SVH

// The condition must hold in the same cycle as the trigger.
`define SACL_ASSERT_SAME(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error(msg);

// The condition must hold in the cycle after the trigger.
`define SACL_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error(msg);

`endif

>>> rtl/sacl_pkg.sv
// ----------------------------------------------------------------------------
// Cache tag block package
// Field widths, register codes and the per-way line record for the RTL modules.
// ----------------------------------------------------------------------------
package sacl_pkg;

  localparam int ADDR_W      = 32;
  localparam int TAG_W       = 32;
  localparam int COUNT_W     = 16;
  localparam int AGE_W       = 8;
  localparam int CYCLE_W     = 48;
  localparam int MISS_W      = 32;
  localparam int TIME_W      = 16;
  localparam int OFFSET_W    = 5;
  localparam int WAY_NUM_W   = 4;   // enough for up to sixteen ways
  localparam int WAY_OUT_W   = 2;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 16;
  localparam int OUT_DATA_W  = 88;
  localparam int OUT_PAD_W   = OUT_DATA_W - WAY_OUT_W - CYCLE_W - MISS_W;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [AGE_W-1:0]   AGE_MAX   = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POLICY       = 4'd0,
    CFG_OFFSET       = 4'd1,
    CFG_HIT_TIME     = 4'd2,
    CFG_MISS_PENALTY = 4'd3
  } cfg_reg_t;

  typedef enum logic {
    POLICY_LRU = 1'b0,
    POLICY_LFU = 1'b1
  } policy_t;

  typedef struct packed {
    logic               valid;
    logic [TAG_W-1:0]   tag;
    logic [COUNT_W-1:0] count;
    logic [AGE_W-1:0]   age;
  } line_t;

  typedef struct packed {
    logic                 hit;
    logic [WAY_NUM_W-1:0] way;
  } access_res_t;

endpackage

>>> rtl/sacl_index.sv
// ----------------------------------------------------------------------------
// Address split
// Derives the set index and the stored tag from a byte address.
// ----------------------------------------------------------------------------
module sacl_index #(
  parameter int SET_BITS = 6,
  parameter int IDX_W    = 6
) (
  input  logic [sacl_pkg::ADDR_W-1:0]   addr,
  input  logic [sacl_pkg::OFFSET_W-1:0] offset,
  output logic [IDX_W-1:0]              set_idx,
  output logic [sacl_pkg::TAG_W-1:0]    tag
);
  import sacl_pkg::*;

  logic [ADDR_W-1:0] shifted;
  logic [6:0]        split;
  logic [63:0]       keep_mask;

  always_comb begin
    shifted   = addr >> offset;
    split     = 7'(offset) + 7'(SET_BITS);
    // Bits at and above the split survive; a split of 32 or more clears the tag.
    keep_mask = {64{1'b1}} << split;
    tag       = addr & keep_mask[TAG_W-1:0];
    set_idx   = (SET_BITS == 0) ? '0 : shifted[IDX_W-1:0];
  end

endmodule

>>> rtl/sacl_row_ram.sv
// ----------------------------------------------------------------------------
// Set row memory
// One row per set holding every way; read data is registered and a write to
// the row being read in the same cycle is passed straight through.
// ----------------------------------------------------------------------------
module sacl_row_ram #(
  parameter int ROWS  = 64,
  parameter int IDX_W = 6,
  parameter int WAYS  = 4
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [IDX_W-1:0]              wr_addr,
  input  sacl_pkg::line_t [WAYS-1:0]    wr_row,
  input  logic                          rd_en,
  input  logic [IDX_W-1:0]              rd_addr,
  output sacl_pkg::line_t [WAYS-1:0]    rd_row_r
);
  import sacl_pkg::*;

  line_t [WAYS-1:0] mem [ROWS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
    if (rd_en) begin
      rd_row_r <= (wr_en && (wr_addr == rd_addr)) ? wr_row : mem[rd_addr];
    end
  end

endmodule

>>> rtl/sacl_update.sv
// ----------------------------------------------------------------------------
// Set update logic
// Looks up the tag in one set row, picks a victim on a miss and builds the
// row to write back with counts and ages moved on.
// ----------------------------------------------------------------------------
module sacl_update #(
  parameter int WAYS = 4
) (
  input  sacl_pkg::line_t [WAYS-1:0]    row,
  input  logic [sacl_pkg::TAG_W-1:0]    tag,
  input  sacl_pkg::policy_t             policy,
  output sacl_pkg::line_t [WAYS-1:0]    new_row,
  output sacl_pkg::access_res_t         res
);
  import sacl_pkg::*;

  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

  logic             hit;
  logic [WAY_W-1:0] hit_way;
  logic             inv_found;
  logic [WAY_W-1:0] inv_way;
  logic [WAY_W-1:0] best;
  logic [WAY_W-1:0] way;

  always_comb begin
    hit       = 1'b0;
    hit_way   = '0;
    inv_found = 1'b0;
    inv_way   = '0;
    best      = '0;

    for (int i = 0; i < WAYS; i++) begin
      if (!hit && row[i].valid && (row[i].tag == tag)) begin
        hit     = 1'b1;
        hit_way = WAY_W'(i);
      end
      if (!inv_found && !row[i].valid) begin
        inv_found = 1'b1;
        inv_way   = WAY_W'(i);
      end
    end

    // Strict comparisons keep the lowest way on a tie.
    for (int i = 1; i < WAYS; i++) begin
      if (policy == POLICY_LFU) begin
        if (row[i].count < row[best].count) begin
          best = WAY_W'(i);
        end
      end else begin
        if (row[i].age > row[best].age) begin
          best = WAY_W'(i);
        end
      end
    end

    if (hit) begin
      way = hit_way;
    end else if (inv_found) begin
      way = inv_way;
    end else begin
      way = best;
    end

    for (int i = 0; i < WAYS; i++) begin
      new_row[i] = row[i];
      if (WAY_W'(i) == way) begin
        new_row[i].age = '0;
        if (hit) begin
          if (row[i].count != COUNT_MAX) begin
            new_row[i].count = row[i].count + 1'b1;
          end
        end else begin
          new_row[i].valid = 1'b1;
          new_row[i].tag   = tag;
          new_row[i].count = '0;
        end
      end else if (row[i].age != AGE_MAX) begin
        new_row[i].age = row[i].age + 1'b1;
      end
    end

    res.hit = hit;
    res.way = WAY_NUM_W'(way);
  end

endmodule

>>> rtl/set_assoc_cache_lru_lfu_top.sv
// ----------------------------------------------------------------------------
// Set-associative cache tag block with LRU or LFU replacement
// Tracks tags, use counts and ages per way and reports hit or miss, the way
// used and running cycle and miss totals for every address transaction.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Carries
//  -------  ---------  ------------------------------------------------------
//  in_      slave      access_address
//  out_     master     was_hit (tuser); way_used, cycle_total, miss_total
//  cfg_     write only replacement_policy, offset_bits, hit_time, miss_penalty
//
// One address transaction is accepted per cycle while the update stage is
// free. Its set row is read into the update stage in the acceptance cycle,
// and its result is registered once the result register is empty or being
// drained. The row write-back of the previous address is passed straight
// into the read so back-to-back hits on one set see fresh state.
// After reset a clearing pass writes all 2**floor(log2(NUM_SETS)) set rows,
// one row a cycle, with in_tready low throughout.
// A stall on out_tready holds the result register and the update stage; the
// input keeps accepting as long as the update stage is free.
//
`include "set_assoc_cache_lru_lfu_top_assert.svh"

module set_assoc_cache_lru_lfu_top #(
  parameter int NUM_SETS = 64,
  parameter int WAYS     = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Address transactions.
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [sacl_pkg::ADDR_W-1:0]       in_tdata,   // [31:0] access_address
  // Result transactions.
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [1:0] way_used, [49:2] cycle_total, [81:50] miss_total, [87:82] zero
  output logic [sacl_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                              out_tuser,  // [0] was_hit
  // Configuration writes.
  input  logic                              cfg_wr_en,
  input  logic [sacl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sacl_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import sacl_pkg::*;

  // The set index uses the largest power of two that fits in NUM_SETS.
  localparam int SET_BITS = $clog2(NUM_SETS + 1) - 1;
  localparam int IDX_W    = (SET_BITS > 0) ? SET_BITS : 1;
  localparam int ROWS     = 1 << SET_BITS;

  // Configuration registers.
  policy_t               policy_r;
  logic [OFFSET_W-1:0]   offset_r;
  logic [TIME_W-1:0]     hit_time_r;
  logic [TIME_W-1:0]     miss_pen_r;

  // Clearing pass.
  logic                  clr_active_r;
  logic [IDX_W-1:0]      clr_idx_r;

  // Update stage: the address whose set row is in the memory read register.
  logic                  s1_valid_r;
  logic [TAG_W-1:0]      s1_tag_r;
  logic [IDX_W-1:0]      s1_idx_r;

  // Result register and running totals.
  logic                  out_valid_r;
  logic                  out_hit_r;
  logic [WAY_OUT_W-1:0]  out_way_r;
  logic [CYCLE_W-1:0]    cycle_sum_r;
  logic [CYCLE_W-1:0]    cycle_sum_nxt;
  logic [MISS_W-1:0]     miss_sum_r;
  logic [MISS_W-1:0]     miss_sum_nxt;

  logic                  in_fire;
  logic                  s1_fire;
  logic [IDX_W-1:0]      in_idx;
  logic [TAG_W-1:0]      in_tag;

  line_t [WAYS-1:0]      rd_row;
  line_t [WAYS-1:0]      upd_row;
  line_t [WAYS-1:0]      wr_row;
  logic [IDX_W-1:0]      wr_addr;
  logic                  wr_en;
  access_res_t           upd_res;

  logic [TIME_W:0]       add_cycles;
  logic [CYCLE_W:0]      cycle_wide;

  // The update stage moves on when the result register is empty or being
  // drained; a new address may enter whenever the update stage frees up.
  assign s1_fire   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !clr_active_r && (!s1_valid_r || s1_fire);
  assign in_fire   = in_tvalid && in_tready;

  sacl_index #(
    .SET_BITS (SET_BITS),
    .IDX_W    (IDX_W)
  ) u_index (
    .addr    (in_tdata),
    .offset  (offset_r),
    .set_idx (in_idx),
    .tag     (in_tag)
  );

  // During the clearing pass the write port zeroes one row a cycle.
  assign wr_en   = clr_active_r || s1_fire;
  assign wr_addr = clr_active_r ? clr_idx_r : s1_idx_r;
  assign wr_row  = clr_active_r ? '0 : upd_row;

  sacl_row_ram #(
    .ROWS  (ROWS),
    .IDX_W (IDX_W),
    .WAYS  (WAYS)
  ) u_ram (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_row   (wr_row),
    .rd_en    (in_fire),
    .rd_addr  (in_idx),
    .rd_row_r (rd_row)
  );

  sacl_update #(
    .WAYS (WAYS)
  ) u_update (
    .row     (rd_row),
    .tag     (s1_tag_r),
    .policy  (policy_r),
    .new_row (upd_row),
    .res     (upd_res)
  );

  // Every access costs the hit time; a miss adds the penalty on top.
  always_comb begin
    add_cycles = {1'b0, hit_time_r} + (upd_res.hit ? '0 : {1'b0, miss_pen_r});
    cycle_wide = {1'b0, cycle_sum_r} + (CYCLE_W + 1)'(add_cycles);
    cycle_sum_nxt = cycle_wide[CYCLE_W] ? '1 : cycle_wide[CYCLE_W-1:0];
    if (upd_res.hit || (miss_sum_r == '1)) begin
      miss_sum_nxt = miss_sum_r;
    end else begin
      miss_sum_nxt = miss_sum_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r   <= POLICY_LRU;
      offset_r   <= OFFSET_W'(4);
      hit_time_r <= TIME_W'(1);
      miss_pen_r <= TIME_W'(100);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_POLICY:       policy_r   <= policy_t'(cfg_wdata[0]);
        CFG_OFFSET:       offset_r   <= cfg_wdata[OFFSET_W-1:0];
        CFG_HIT_TIME:     hit_time_r <= cfg_wdata[TIME_W-1:0];
        CFG_MISS_PENALTY: miss_pen_r <= cfg_wdata[TIME_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_idx_r    <= '0;
    end else if (clr_active_r) begin
      if (clr_idx_r == IDX_W'(ROWS - 1)) begin
        clr_active_r <= 1'b0;
      end else begin
        clr_idx_r <= clr_idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      cycle_sum_r <= '0;
      miss_sum_r  <= '0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_r <= 1'b1;
        cycle_sum_r <= cycle_sum_nxt;
        miss_sum_r  <= miss_sum_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_tag_r <= in_tag;
      s1_idx_r <= in_idx;
    end
    if (s1_fire) begin
      out_hit_r <= upd_res.hit;
      out_way_r <= upd_res.way[WAY_OUT_W-1:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_hit_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, miss_sum_r, cycle_sum_r, out_way_r};

  // Checks on the block's own logic.
  `SACL_ASSERT_SAME(a_no_accept_while_clearing, clr_active_r, !in_tready,
                    "address accepted during the clearing pass")
  `SACL_ASSERT_NEXT(a_hit_keeps_miss_total, s1_fire && upd_res.hit, $stable(miss_sum_r),
                    "miss total moved on a hit")
  `SACL_ASSERT_NEXT(a_cycle_total_grows, s1_fire, cycle_sum_r >= $past(cycle_sum_r),
                    "cycle total went down")
  `SACL_ASSERT_NEXT(a_update_loads_result, s1_fire, out_valid_r,
                    "update stage fired without loading the result register")

endmodule
